>>> rtl/core/cwg_pkg.sv
// ----------------------------------------------------------------------------
// Clipped rectangle window command generator package
// Shared types, register indexes, link word slots and reset values.
// ----------------------------------------------------------------------------
package cwg_pkg;

	localparam int unsigned PANEL_WIDTH_DEF  = 176;
	localparam int unsigned PANEL_HEIGHT_DEF = 220;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [7:0] COLUMN_SET_RST   = 8'd42;
	localparam logic [7:0] PAGE_SET_RST     = 8'd43;
	localparam logic [7:0] MEMORY_WRITE_RST = 8'd44;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROTATION     = 8'd0,
		REG_COLUMN_SET   = 8'd1,
		REG_PAGE_SET     = 8'd2,
		REG_MEMORY_WRITE = 8'd3
	} cwg_reg_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} cwg_rot_t;

	typedef enum logic [3:0] {
		SLOT_CASET    = 4'd0,
		SLOT_XS_HI    = 4'd1,
		SLOT_XS_LO    = 4'd2,
		SLOT_XE_HI    = 4'd3,
		SLOT_XE_LO    = 4'd4,
		SLOT_PASET    = 4'd5,
		SLOT_YS_HI    = 4'd6,
		SLOT_YS_LO    = 4'd7,
		SLOT_YE_HI    = 4'd8,
		SLOT_YE_LO    = 4'd9,
		SLOT_RAMWR    = 4'd10
	} cwg_slot_t;

	typedef struct packed {
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
	} cwg_req_t;

	typedef struct packed {
		logic        is_data;
		logic [7:0]  out_byte;
		logic [15:0] pixel_count;
		logic        last;
	} cwg_word_t;

endpackage

>>> rtl/core/clipped_rect_window_command_gen_core.sv
// ----------------------------------------------------------------------------
// Clipped rectangle window command generator
// Clips a signed rectangle to the rotated screen and emits the window setup
// link words for the panel.
// ----------------------------------------------------------------------------
// Each accepted rectangle that is not empty and not wholly off screen produces
// eleven link words: column-set command, four column bytes, page-set command,
// four page bytes and the memory-write command, which carries the pixel count
// and the last flag. Dropped rectangles produce nothing. When the block is
// empty, a request passes through the request register, the clipped window
// register and the panel window register, from which its first word is presented.
// The output sequencer sends one word per cycle while out_ready is high, so a
// rectangle occupies it for eleven words; the two stages ahead of it can each
// hold one more request while it is busy. Configuration writes are always
// accepted and should only be issued while the block is idle.

module clipped_rect_window_command_gen_core #(
	parameter int unsigned PANEL_WIDTH  = cwg_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = cwg_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  cwg_pkg::cwg_req_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cwg_pkg::cwg_word_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cwg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cwg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [7:0] PW       = 8'(PANEL_WIDTH);
	localparam logic [7:0] PH       = 8'(PANEL_HEIGHT);
	localparam logic [7:0] PW_LAST  = 8'(PANEL_WIDTH - 1);
	localparam logic [7:0] PH_LAST  = 8'(PANEL_HEIGHT - 1);

	cwg_pkg::cwg_rot_t  rotation_q;
	logic [7:0]         column_set_q;
	logic [7:0]         page_set_q;
	logic [7:0]         memory_write_q;

	logic               valid_s1;
	cwg_pkg::cwg_req_t  req_s1;

	logic               valid_s2;
	logic [7:0]         x0_s2;
	logic [7:0]         x1_s2;
	logic [7:0]         y0_s2;
	logic [7:0]         y1_s2;

	logic               valid_s3;
	logic [7:0]         px0_s3;
	logic [7:0]         px1_s3;
	logic [7:0]         py0_s3;
	logic [7:0]         py1_s3;
	logic [15:0]        count_s3;
	cwg_pkg::cwg_slot_t slot_q;

	logic               free_s1;
	logic               free_s2;
	logic               free_s3;

	logic [7:0]         lw;
	logic [7:0]         lh;
	logic signed [17:0] x_e;
	logic signed [17:0] y_e;
	logic signed [17:0] w_e;
	logic signed [17:0] h_e;
	logic signed [17:0] x2_e;
	logic signed [17:0] y2_e;
	logic signed [17:0] lw_e;
	logic signed [17:0] lh_e;
	logic               keep;
	logic [7:0]         x0_c;
	logic [7:0]         x1_c;
	logic [7:0]         y0_c;
	logic [7:0]         y1_c;

	logic [7:0]         cw;
	logic [7:0]         ch;
	logic [15:0]        count_c;
	logic [7:0]         px0_c;
	logic [7:0]         px1_c;
	logic [7:0]         py0_c;
	logic [7:0]         py1_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q     <= cwg_pkg::ROT_0;
			column_set_q   <= cwg_pkg::COLUMN_SET_RST;
			page_set_q     <= cwg_pkg::PAGE_SET_RST;
			memory_write_q <= cwg_pkg::MEMORY_WRITE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cwg_pkg::REG_ROTATION:     rotation_q     <= cwg_pkg::cwg_rot_t'(cfg_data[1:0]);
				cwg_pkg::REG_COLUMN_SET:   column_set_q   <= cfg_data;
				cwg_pkg::REG_PAGE_SET:     page_set_q     <= cfg_data;
				cwg_pkg::REG_MEMORY_WRITE: memory_write_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage is free when it is empty or its content moves on in this cycle.
	assign free_s3  = !valid_s3 || (out_ready && (slot_q == cwg_pkg::SLOT_RAMWR));
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_ready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// Clipping against the logical screen, with edges kept exact in 18 bits.
	always_comb begin
		lw   = rotation_q[0] ? PH : PW;
		lh   = rotation_q[0] ? PW : PH;
		x_e  = {{2{req_s1.rect_x[15]}}, req_s1.rect_x};
		y_e  = {{2{req_s1.rect_y[15]}}, req_s1.rect_y};
		w_e  = {{2{req_s1.rect_w[15]}}, req_s1.rect_w};
		h_e  = {{2{req_s1.rect_h[15]}}, req_s1.rect_h};
		x2_e = x_e + w_e - 18'sd1;
		y2_e = y_e + h_e - 18'sd1;
		lw_e = signed'({10'd0, lw});
		lh_e = signed'({10'd0, lh});
		keep = (w_e > 18'sd0) && (h_e > 18'sd0) && (x_e < lw_e) && (y_e < lh_e)
			&& (x2_e >= 18'sd0) && (y2_e >= 18'sd0);
		x0_c = x_e[17] ? 8'd0 : x_e[7:0];
		y0_c = y_e[17] ? 8'd0 : y_e[7:0];
		x1_c = (x2_e >= lw_e) ? (lw - 8'd1) : x2_e[7:0];
		y1_c = (y2_e >= lh_e) ? (lh - 8'd1) : y2_e[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1) begin
			x0_s2 <= x0_c;
			x1_s2 <= x1_c;
			y0_s2 <= y0_c;
			y1_s2 <= y1_c;
		end
	end

	// Mapping of the clipped window to panel coordinates and pixel count.
	always_comb begin
		cw      = x1_s2 - x0_s2 + 8'd1;
		ch      = y1_s2 - y0_s2 + 8'd1;
		count_c = {8'd0, cw} * {8'd0, ch};
		case (rotation_q)
			cwg_pkg::ROT_90: begin
				px0_c = PW_LAST - y1_s2;
				px1_c = PW_LAST - y0_s2;
				py0_c = x0_s2;
				py1_c = x1_s2;
			end
			cwg_pkg::ROT_180: begin
				px0_c = PW_LAST - x1_s2;
				px1_c = PW_LAST - x0_s2;
				py0_c = PH_LAST - y1_s2;
				py1_c = PH_LAST - y0_s2;
			end
			cwg_pkg::ROT_270: begin
				px0_c = y0_s2;
				px1_c = y1_s2;
				py0_c = PH_LAST - x1_s2;
				py1_c = PH_LAST - x0_s2;
			end
			default: begin
				px0_c = x0_s2;
				px1_c = x1_s2;
				py0_c = y0_s2;
				py1_c = y1_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			slot_q   <= cwg_pkg::SLOT_CASET;
		end else if (free_s3) begin
			valid_s3 <= valid_s2;
			slot_q   <= cwg_pkg::SLOT_CASET;
		end else if (out_ready) begin
			slot_q <= cwg_pkg::cwg_slot_t'(slot_q + 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			px0_s3   <= px0_c;
			px1_s3   <= px1_c;
			py0_s3   <= py0_c;
			py1_s3   <= py1_c;
			count_s3 <= count_c;
		end
	end

	assign out_valid = valid_s3;

	always_comb begin
		out_data.is_data     = 1'b1;
		out_data.out_byte    = 8'd0;
		out_data.pixel_count = 16'd0;
		out_data.last        = 1'b0;
		case (slot_q)
			cwg_pkg::SLOT_CASET: begin
				out_data.is_data  = 1'b0;
				out_data.out_byte = column_set_q;
			end
			cwg_pkg::SLOT_XS_LO: out_data.out_byte = px0_s3;
			cwg_pkg::SLOT_XE_LO: out_data.out_byte = px1_s3;
			cwg_pkg::SLOT_PASET: begin
				out_data.is_data  = 1'b0;
				out_data.out_byte = page_set_q;
			end
			cwg_pkg::SLOT_YS_LO: out_data.out_byte = py0_s3;
			cwg_pkg::SLOT_YE_LO: out_data.out_byte = py1_s3;
			cwg_pkg::SLOT_RAMWR: begin
				out_data.is_data     = 1'b0;
				out_data.out_byte    = memory_write_q;
				out_data.pixel_count = count_s3;
				out_data.last        = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
